/* rtl/x86_rotate_unit_core_assert.svh */
// ----------------------------------------------------------------------------
// x86 rotate unit assertion macros
// shared property forms for the rotate unit checkers, clocked on clk and
// disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef X86_ROTATE_UNIT_CORE_ASSERT_SVH
`define X86_ROTATE_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define XRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XRU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xru_pkg.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit package
// operation and width codes, pipeline widths and the structs that travel
// between the pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

package xru_pkg;

  localparam logic [2:0] OP_ROL  = 3'd0;
  localparam logic [2:0] OP_ROR  = 3'd1;
  localparam logic [2:0] OP_RCL  = 3'd2;
  localparam logic [2:0] OP_RCR  = 3'd3;
  localparam logic [2:0] OP_RORX = 3'd4;

  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  localparam logic [5:0] CNT_MASK_64 = 6'h3F;
  localparam logic [5:0] CNT_MASK_32 = 6'h1F;

  // ring holds the operand plus the carry slot, doubled for the rotate
  localparam int RING_W = 65;
  localparam int DBL_W  = 2 * RING_W;
  localparam int CRS_W  = RING_W + 7;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] wc;
    logic       cin;
    logic       oin;
    logic       tc_zero;
    logic       tc_one;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [6:0]       shamt;
    logic [DBL_W-1:0] ring2;
  } dec_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [2:0]       fine;
    logic [CRS_W-1:0] part;
  } crs_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [RING_W-1:0] rot;
  } rot_t;

endpackage

`default_nettype wire

/* rtl/xru_decode.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit decode stage
// reduces the count, works out the right-shift amount on the doubled ring
// and builds the ring of operand and carry
// ----------------------------------------------------------------------------
`default_nettype none

module xru_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire logic [2:0]    req_type,
  input  wire logic [1:0]    width_code,
  input  wire logic [63:0]   operand_value,
  input  wire logic [7:0]    rotate_count,
  input  wire logic          carry_in,
  input  wire logic          overflow_in,
  output logic               dec_vld,
  input  wire logic          dec_rdy,
  output xru_pkg::dec_t      dec
);

  function automatic logic [3:0] mod_nine(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd27) begin
      r = v - 5'd27;
    end else if (v >= 5'd18) begin
      r = v - 5'd18;
    end else if (v >= 5'd9) begin
      r = v - 5'd9;
    end else begin
      r = v;
    end
    return r[3:0];
  endfunction

  logic [5:0]                   masked;
  logic [4:0]                   mod17;
  logic                         is_rc;
  logic                         is_left;
  logic                         known;
  logic [5:0]                   tc;
  logic [6:0]                   n;
  logic [xru_pkg::RING_W-1:0]   ring;
  xru_pkg::dec_t                dec_next;

  assign req_ready = !dec_vld || dec_rdy;

  always_comb begin
    masked  = rotate_count[5:0] &
              ((width_code == xru_pkg::WC_64) ? xru_pkg::CNT_MASK_64 : xru_pkg::CNT_MASK_32);
    mod17   = (masked[4:0] >= 5'd17) ? (masked[4:0] - 5'd17) : masked[4:0];
    is_rc   = (req_type == xru_pkg::OP_RCL) || (req_type == xru_pkg::OP_RCR);
    is_left = (req_type == xru_pkg::OP_ROL) || (req_type == xru_pkg::OP_RCL);
    known   = (req_type <= xru_pkg::OP_RORX);

    unique case (width_code)
      xru_pkg::WC_8: begin
        tc   = is_rc ? {2'b00, mod_nine(masked[4:0])} : {3'b000, masked[2:0]};
        ring = xru_pkg::RING_W'({carry_in & is_rc, operand_value[7:0]});
      end
      xru_pkg::WC_16: begin
        tc   = is_rc ? {1'b0, mod17} : {2'b00, masked[3:0]};
        ring = xru_pkg::RING_W'({carry_in & is_rc, operand_value[15:0]});
      end
      xru_pkg::WC_32: begin
        tc   = {1'b0, masked[4:0]};
        ring = xru_pkg::RING_W'({carry_in & is_rc, operand_value[31:0]});
      end
      default: begin
        tc   = masked;
        ring = {carry_in & is_rc, operand_value};
      end
    endcase

    if (!known) begin
      tc = 6'd0;
    end

    n = (7'd8 << width_code) + {6'b0, is_rc};

    dec_next.ctl.op      = req_type;
    dec_next.ctl.wc      = width_code;
    dec_next.ctl.cin     = carry_in;
    dec_next.ctl.oin     = overflow_in;
    dec_next.ctl.tc_zero = (tc == 6'd0);
    dec_next.ctl.tc_one  = (tc == 6'd1);
    dec_next.shamt       = is_left ? (n - {1'b0, tc}) : {1'b0, tc};

    unique case (width_code)
      xru_pkg::WC_8: begin
        dec_next.ring2 = is_rc ? xru_pkg::DBL_W'({ring[8:0], ring[8:0]})
                               : xru_pkg::DBL_W'({ring[7:0], ring[7:0]});
      end
      xru_pkg::WC_16: begin
        dec_next.ring2 = is_rc ? xru_pkg::DBL_W'({ring[16:0], ring[16:0]})
                               : xru_pkg::DBL_W'({ring[15:0], ring[15:0]});
      end
      xru_pkg::WC_32: begin
        dec_next.ring2 = is_rc ? xru_pkg::DBL_W'({ring[32:0], ring[32:0]})
                               : xru_pkg::DBL_W'({ring[31:0], ring[31:0]});
      end
      default: begin
        dec_next.ring2 = is_rc ? {ring[64:0], ring[64:0]}
                               : xru_pkg::DBL_W'({ring[63:0], ring[63:0]});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_vld <= 1'b0;
    end else if (req_ready) begin
      dec_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      dec <= dec_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/xru_shift.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit shifter
// two register stages: a coarse right shift in steps of eight bits, then a
// fine right shift of up to seven bits on the doubled ring
// ----------------------------------------------------------------------------
`default_nettype none

module xru_shift (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          dec_vld,
  output logic               dec_rdy,
  input  wire xru_pkg::dec_t dec,
  output logic               rot_vld,
  input  wire logic          rot_rdy,
  output xru_pkg::rot_t      rot
);

  logic          crs_vld;
  logic          crs_rdy;
  xru_pkg::crs_t crs;
  xru_pkg::crs_t crs_next;
  xru_pkg::rot_t rot_next;

  assign crs_rdy = !rot_vld || rot_rdy;
  assign dec_rdy = !crs_vld || crs_rdy;

  always_comb begin
    crs_next.ctl  = dec.ctl;
    crs_next.fine = dec.shamt[2:0];
    crs_next.part = xru_pkg::CRS_W'(dec.ring2 >> {dec.shamt[6:3], 3'b000});
  end

  always_comb begin
    rot_next.ctl = crs.ctl;
    rot_next.rot = xru_pkg::RING_W'(crs.part >> crs.fine);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crs_vld <= 1'b0;
      rot_vld <= 1'b0;
    end else begin
      if (dec_rdy) begin
        crs_vld <= dec_vld;
      end
      if (crs_rdy) begin
        rot_vld <= crs_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_rdy && dec_vld) begin
      crs <= crs_next;
    end
    if (crs_rdy && crs_vld) begin
      rot <= rot_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/xru_flags.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit flag stage
// trims the rotated ring to the operand width, forms CF and OF and holds
// the result in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module xru_flags (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rot_vld,
  output logic               rot_rdy,
  input  wire xru_pkg::rot_t rot,
  output logic               res_valid,
  input  wire logic          res_ready,
  output logic [63:0]        result_value,
  output logic               carry_out,
  output logic               overflow_out,
  output logic               overflow_undefined
);

  logic [63:0] value_next;
  logic        msb;
  logic        msb2;
  logic        rc_carry;
  logic        cf_next;
  logic        of_next;
  logic        und_next;

  assign rot_rdy = !res_valid || res_ready;

  always_comb begin
    unique case (rot.ctl.wc)
      xru_pkg::WC_8: begin
        value_next = {56'b0, rot.rot[7:0]};
        msb        = rot.rot[7];
        msb2       = rot.rot[6];
        rc_carry   = rot.rot[8];
      end
      xru_pkg::WC_16: begin
        value_next = {48'b0, rot.rot[15:0]};
        msb        = rot.rot[15];
        msb2       = rot.rot[14];
        rc_carry   = rot.rot[16];
      end
      xru_pkg::WC_32: begin
        value_next = {32'b0, rot.rot[31:0]};
        msb        = rot.rot[31];
        msb2       = rot.rot[30];
        rc_carry   = rot.rot[32];
      end
      default: begin
        value_next = rot.rot[63:0];
        msb        = rot.rot[63];
        msb2       = rot.rot[62];
        rc_carry   = rot.rot[64];
      end
    endcase

    cf_next  = rot.ctl.cin;
    of_next  = rot.ctl.oin;
    und_next = 1'b0;

    if (!rot.ctl.tc_zero && (rot.ctl.op != xru_pkg::OP_RORX)) begin
      unique case (rot.ctl.op)
        xru_pkg::OP_ROL: cf_next = value_next[0];
        xru_pkg::OP_ROR: cf_next = msb;
        default:         cf_next = rc_carry;
      endcase
      if (rot.ctl.tc_one) begin
        if ((rot.ctl.op == xru_pkg::OP_ROL) || (rot.ctl.op == xru_pkg::OP_RCL)) begin
          of_next = msb ^ cf_next;
        end else begin
          of_next = msb ^ msb2;
        end
      end else begin
        of_next  = 1'b0;
        und_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rot_rdy) begin
      res_valid <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rot_rdy && rot_vld) begin
      result_value       <= value_next;
      carry_out          <= cf_next;
      overflow_out       <= of_next;
      overflow_undefined <= und_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/x86_rotate_unit_core.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit core
// ROL, ROR, RCL, RCR and RORX on 8, 16, 32 or 64 bit operands
//
// channel   handshake              payload
// request   req_valid, req_ready   req_type, width_code, operand_value,
//                                  rotate_count, carry_in, overflow_in
// result    res_valid, res_ready   result_value, carry_out, overflow_out,
//                                  overflow_undefined
//
// one request per cycle while res_ready is high
// four register stages: decode, coarse shift, fine shift, flags
// reset clears the stage valid bits only
// res_ready low holds the output register, empty stages behind it still fill
// req_ready falls only once every stage holds a request
// ----------------------------------------------------------------------------
`default_nettype none

module x86_rotate_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [1:0]  width_code,
  input  wire logic [63:0] operand_value,
  input  wire logic [7:0]  rotate_count,
  input  wire logic        carry_in,
  input  wire logic        overflow_in,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [63:0]      result_value,
  output logic             carry_out,
  output logic             overflow_out,
  output logic             overflow_undefined
);

  logic          dec_vld;
  logic          dec_rdy;
  xru_pkg::dec_t dec;
  logic          rot_vld;
  logic          rot_rdy;
  xru_pkg::rot_t rot;

  xru_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req_type      (req_type),
    .width_code    (width_code),
    .operand_value (operand_value),
    .rotate_count  (rotate_count),
    .carry_in      (carry_in),
    .overflow_in   (overflow_in),
    .dec_vld       (dec_vld),
    .dec_rdy       (dec_rdy),
    .dec           (dec)
  );

  xru_shift u_shift (
    .clk     (clk),
    .rst     (rst),
    .dec_vld (dec_vld),
    .dec_rdy (dec_rdy),
    .dec     (dec),
    .rot_vld (rot_vld),
    .rot_rdy (rot_rdy),
    .rot     (rot)
  );

  xru_flags u_flags (
    .clk                (clk),
    .rst                (rst),
    .rot_vld            (rot_vld),
    .rot_rdy            (rot_rdy),
    .rot                (rot),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .result_value       (result_value),
    .carry_out          (carry_out),
    .overflow_out       (overflow_out),
    .overflow_undefined (overflow_undefined)
  );

endmodule

`default_nettype wire

/* rtl/xru_checker.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit checker
// port-level properties of the rotate unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "x86_rotate_unit_core_assert.svh"

module xru_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [63:0] result_value,
  input wire logic        overflow_out,
  input wire logic        overflow_undefined
);

  `XRU_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(result_value), "result dropped or changed while stalled")
  `XRU_ASSERT_IMP(a_no_backpressure, res_ready, req_ready, "request stalled with result side ready")
  `XRU_ASSERT_NXT(a_latency, (req_valid && req_ready) ##1 res_ready [*3], res_valid, "request late")
  `XRU_ASSERT_IMP(a_of_undef_zero, res_valid && overflow_undefined, !overflow_out, "undefined OF not forced low")

endmodule

bind x86_rotate_unit_core xru_checker u_xru_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req_valid),
  .req_ready          (req_ready),
  .res_valid          (res_valid),
  .res_ready          (res_ready),
  .result_value       (result_value),
  .overflow_out       (overflow_out),
  .overflow_undefined (overflow_undefined)
);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// x86 rotate unit testbench
// drives ROL, ROR, RCL, RCR and RORX requests through the core and checks
// every result and flag against a predictor built into the bench; directed
// cases cover zero and unit counts, undefined OF and field extremes, then a
// random stream runs with random idling, a long output stall and drain pauses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

  typedef struct {
    logic [63:0] value;
    logic        cf;
    logic        of;
    logic        of_undef;
  } rot_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  logic [2:0]  req_type;
  logic [1:0]  width_code;
  logic [63:0] operand_value;
  logic [7:0]  rotate_count;
  logic        carry_in;
  logic        overflow_in;
  logic        res_valid;
  logic        res_ready;
  logic [63:0] result_value;
  logic        carry_out;
  logic        overflow_out;
  logic        overflow_undefined;

  rot_result_t pending_rotations[$];
  bit          src_idle;
  bit          sink_idle;
  int          hold_len;
  int          mismatch_count;
  int          requests_sent;
  int          results_seen;
  int          undef_requests;
  int          input_stall_cycles;

  x86_rotate_unit_core u_top (
    .clk                (clk),
    .rst                (rst),
    .req_valid          (req_valid),
    .req_ready          (req_ready),
    .req_type           (req_type),
    .width_code         (width_code),
    .operand_value      (operand_value),
    .rotate_count       (rotate_count),
    .carry_in           (carry_in),
    .overflow_in        (overflow_in),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .result_value       (result_value),
    .carry_out          (carry_out),
    .overflow_out       (overflow_out),
    .overflow_undefined (overflow_undefined)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic rot_result_t predict_rotate(input logic [2:0] op, input logic [1:0] wc,
                                                 input logic [63:0] opnd,
                                                 input logic [7:0] cnt, input logic cin,
                                                 input logic oin);
    rot_result_t r;
    int unsigned w;
    int unsigned tc;
    int unsigned masked;
    logic [63:0] wmask;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] c64;
    logic [5:0]  cmask;
    logic        cf;
    logic        of;
    logic        und;
    logic        msb;
    logic        msb2;
    w      = 8 << wc;
    wmask  = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    v      = opnd & wmask;
    cmask  = (wc == xru_pkg::WC_64) ? xru_pkg::CNT_MASK_64 : xru_pkg::CNT_MASK_32;
    masked = int'(cnt & {2'b00, cmask});
    c64    = {63'd0, cin};
    res    = v;
    cf     = cin;
    of     = oin;
    und    = 1'b0;
    case (op)
      xru_pkg::OP_ROL, xru_pkg::OP_ROR, xru_pkg::OP_RORX: tc = masked % w;
      xru_pkg::OP_RCL, xru_pkg::OP_RCR:
        tc = masked % ((w < 32) ? w + 1 : int'(cmask) + 1);
      default: tc = 0;
    endcase
    if (tc != 0) begin
      case (op)
        xru_pkg::OP_ROL: begin
          res = ((v << tc) | (v >> (w - tc))) & wmask;
          cf  = res[0];
        end
        xru_pkg::OP_ROR, xru_pkg::OP_RORX: begin
          res = ((v >> tc) | (v << (w - tc))) & wmask;
          cf  = res[w - 1];
        end
        xru_pkg::OP_RCL: begin
          res = ((v << tc) | (c64 << (tc - 1)) | (v >> (w - tc + 1))) & wmask;
          cf  = v[w - tc];
        end
        default: begin
          res = ((v >> tc) | (c64 << (w - tc)) | (v << (w - tc + 1))) & wmask;
          cf  = v[tc - 1];
        end
      endcase
      if (op == xru_pkg::OP_RORX) begin
        cf = cin;
      end else if (tc == 1) begin
        msb  = res[w - 1];
        msb2 = res[w - 2];
        of   = (op == xru_pkg::OP_ROL || op == xru_pkg::OP_RCL) ? (msb ^ cf) : (msb ^ msb2);
      end else begin
        of  = 1'b0;
        und = 1'b1;
      end
    end
    r.value    = res;
    r.cf       = cf;
    r.of       = of;
    r.of_undef = und;
    return r;
  endfunction

  task automatic issue_rotate(input logic [2:0] op, input logic [1:0] wc,
                              input logic [63:0] opnd, input logic [7:0] cnt,
                              input logic cin, input logic oin);
    int          gap;
    rot_result_t r;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid     <= 1'b1;
    req_type      <= op;
    width_code    <= wc;
    operand_value <= opnd;
    rotate_count  <= cnt;
    carry_in      <= cin;
    overflow_in   <= oin;
    do @(posedge clk); while (!req_ready);
    r = predict_rotate(op, wc, opnd, cnt, cin, oin);
    pending_rotations.push_back(r);
    requests_sent++;
    if (r.of_undef) undef_requests++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle_pipeline();
    int n;
    n = 0;
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (pending_rotations.size() != 0 && n < 4000);
  endtask

  function automatic logic [63:0] random_operand();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] random_count(input logic [1:0] wc);
    int w;
    w = 8 << wc;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom_range(0, 2));
      3, 4: return 8'(w - 1 + $urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic issue_random_rotate();
    logic [1:0] wc;
    wc = 2'($urandom_range(xru_pkg::WC_8, xru_pkg::WC_64));
    issue_rotate(3'($urandom_range(xru_pkg::OP_ROL, xru_pkg::OP_RORX)), wc,
                 random_operand(), random_count(wc), 1'($urandom), 1'($urandom));
  endtask

  task automatic test_pass_through();
    issue_rotate(xru_pkg::OP_ROL, xru_pkg::WC_8, 64'h0123_4567_89ab_cdef, 8'd8, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_16, 64'hffff_ffff_ffff_8001, 8'd17, 1'b0, 1'b1);
    issue_rotate(xru_pkg::OP_RCR, xru_pkg::WC_32, 64'h8000_0000_dead_beef, 8'd32, 1'b1, 1'b0);
    issue_rotate(xru_pkg::OP_ROR, xru_pkg::WC_64, 64'hfedc_ba98_7654_3210, 8'd64, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RORX, xru_pkg::WC_32, 64'h0000_0001_8000_0001, 8'd0, 1'b0, 1'b1);
    settle_pipeline();
  endtask

  task automatic test_count_of_one();
    issue_rotate(xru_pkg::OP_ROL, xru_pkg::WC_8, 64'h81, 8'd1, 1'b0, 1'b0);
    issue_rotate(xru_pkg::OP_ROR, xru_pkg::WC_16, 64'h0001, 8'd1, 1'b0, 1'b0);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_32, 64'h8000_0000, 8'd1, 1'b1, 1'b0);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_8, 64'h40, 8'd1, 1'b0, 1'b1);
    issue_rotate(xru_pkg::OP_RCR, xru_pkg::WC_64, 64'h1, 8'd1, 1'b1, 1'b0);
    issue_rotate(xru_pkg::OP_RORX, xru_pkg::WC_64, 64'h3, 8'd1, 1'b1, 1'b1);
    settle_pipeline();
  endtask

  task automatic test_undefined_of();
    issue_rotate(xru_pkg::OP_ROL, xru_pkg::WC_64, 64'h8000_0000_0000_0001, 8'd63, 1'b0, 1'b1);
    issue_rotate(xru_pkg::OP_ROR, xru_pkg::WC_8, 64'h5a, 8'd255, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_8, 64'h80, 8'd8, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RCR, xru_pkg::WC_16, 64'h0001, 8'd16, 1'b0, 1'b1);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_64, 64'hc000_0000_0000_0003, 8'h3f, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RCR, xru_pkg::WC_32, 64'h7fff_ffff, 8'd31, 1'b1, 1'b0);
    issue_rotate(xru_pkg::OP_RORX, xru_pkg::WC_16, 64'h1234, 8'd15, 1'b0, 1'b1);
    settle_pipeline();
  endtask

  task automatic test_field_extremes();
    issue_rotate(xru_pkg::OP_ROL, xru_pkg::WC_64, '1, 8'hff, 1'b0, 1'b0);
    issue_rotate(xru_pkg::OP_ROR, xru_pkg::WC_64, '0, 8'h3f, 1'b1, 1'b1);
    issue_rotate(xru_pkg::OP_RCR, xru_pkg::WC_8, '1, 8'd9, 1'b0, 1'b1);
    issue_rotate(xru_pkg::OP_RCL, xru_pkg::WC_16, 64'hffff_0000_0000_8001, 8'hf0, 1'b1, 1'b0);
    settle_pipeline();
  endtask

  // four idling mixes, each ending with a full drain
  task automatic test_random_stream(input int n);
    for (int phase = 0; phase < 4; phase++) begin
      src_idle  = (phase == 0 || phase == 2);
      sink_idle = (phase == 0 || phase == 3);
      repeat (n / 4) issue_random_rotate();
      settle_pipeline();
    end
  endtask

  // long output stall while requests keep coming, so the input backs up
  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_len  = 80;
    repeat (30) issue_random_rotate();
    settle_pipeline();
    sink_idle = 1'b1;
    hold_len  = 40;
    repeat (20) issue_random_rotate();
    settle_pipeline();
  endtask

  initial begin : result_sink
    int stall;
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid && hold_len == 0);
    end
  end

  always @(posedge clk) begin : check_rotation
    rot_result_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_rotations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result value=%h cf=%b of=%b und=%b", $realtime,
                   result_value, carry_out, overflow_out, overflow_undefined);
      end else begin
        want = pending_rotations.pop_front();
        if (result_value !== want.value || carry_out !== want.cf ||
            overflow_out !== want.of || overflow_undefined !== want.of_undef) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp value=%h cf=%b of=%b und=%b, got value=%h cf=%b of=%b und=%b",
                     $realtime, want.value, want.cf, want.of, want.of_undef,
                     result_value, carry_out, overflow_out, overflow_undefined);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && !req_ready) input_stall_cycles++;
  end

  initial begin
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    req_type      <= xru_pkg::OP_ROL;
    width_code    <= xru_pkg::WC_8;
    operand_value <= '0;
    rotate_count  <= '0;
    carry_in      <= 1'b0;
    overflow_in   <= 1'b0;
    src_idle       = 1'b1;
    sink_idle      = 1'b1;
    hold_len       = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pass_through();
    test_count_of_one();
    test_undefined_of();
    test_field_extremes();
    test_random_stream(700);
    test_backpressure();

    repeat (8) @(posedge clk);
    if (pending_rotations.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", pending_rotations.size());
    end
    $display("ran %0d requests across all operations and widths, %0d with OF undefined",
             requests_sent, undef_requests);
    $display("checked %0d results, request side held off for %0d cycles, %0d mismatches",
             results_seen, input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
